// ===== hw/rtl/alux_pkg.sv =====
package alux_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_GAIN  = 2'd0;
  localparam logic [1:0] CFG_ITIME = 2'd1;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 4;

  // gain codes
  localparam logic [1:0] GAIN_X1    = 2'd0;
  localparam logic [1:0] GAIN_X2    = 2'd1;
  localparam logic [1:0] GAIN_DIV8  = 2'd2;
  localparam logic [1:0] GAIN_DIV4  = 2'd3;

  // integration time codes
  localparam logic [3:0] IT_100MS = 4'd0;
  localparam logic [3:0] IT_200MS = 4'd1;
  localparam logic [3:0] IT_400MS = 4'd2;
  localparam logic [3:0] IT_800MS = 4'd3;
  localparam logic [3:0] IT_50MS  = 4'd8;

  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned RAW_W  = 16;
  localparam int unsigned BASE_W = 33;
  localparam int unsigned SP_W   = RAW_W + BASE_W;  // raw * base
  localparam int unsigned SH_W   = 5;
  localparam int unsigned X_W    = 31;              // linear estimate, 14 fraction bits
  localparam int unsigned T_W    = 34;              // Horner partial sums, signed
  localparam int unsigned P_W    = X_W + 1 + T_W;   // signed products
  localparam int unsigned LUX_W  = 35;

  localparam logic [BASE_W-1:0] BASE_Q40 = 33'd7916483720;
  localparam logic signed [T_W-1:0] COEF3 = 34'sd2839795084;
  localparam logic signed [T_W-1:0] COEF2 = -34'sd338396873;
  localparam logic signed [T_W-1:0] COEF1 = 34'sd22399251;
  localparam logic signed [T_W-1:0] COEF0 = 34'sd4203951;

  localparam logic [LUX_W-1:0] LUX_MAX = '1;

  // right shift that turns raw * base into x: 26 - (n + g)
  function automatic logic [SH_W-1:0] scale_shift(input logic [1:0] gain,
                                                   input logic [3:0] itime);
    logic [2:0] n;
    logic [2:0] g1;  // gain exponent plus one
    unique case (itime)
      IT_100MS: n = 3'd3;
      IT_200MS: n = 3'd2;
      IT_400MS: n = 3'd1;
      IT_800MS: n = 3'd0;
      IT_50MS:  n = 3'd4;
      default:  n = 3'd5;  // 25 ms and unknown codes
    endcase
    unique case (gain)
      GAIN_X1:   g1 = 3'd1;
      GAIN_X2:   g1 = 3'd0;
      GAIN_DIV8: g1 = 3'd4;
      GAIN_DIV4: g1 = 3'd3;
      default:   g1 = 3'd1;
    endcase
    return SH_W'(27) - SH_W'(n) - SH_W'(g1);
  endfunction

endpackage

// ===== hw/rtl/alux_scale.sv =====
module alux_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_in,
  input  logic [alux_pkg::RAW_W-1:0]    raw_in,
  input  logic [1:0]                    gain_in,
  input  logic [3:0]                    itime_in,
  output logic                          valid_out,
  output logic [alux_pkg::X_W-1:0]      x_out
);
  import alux_pkg::*;

  logic              v1_r, v2_r;
  logic [SP_W-1:0]   prod_r, prod_nxt;
  logic [SH_W-1:0]   sh_r, sh_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [SP_W:0]     sum;
  logic [SP_W:0]     half;

  assign prod_nxt = raw_in * BASE_Q40;
  assign sh_nxt   = scale_shift(gain_in, itime_in);

  // round half up, then drop the shifted-out bits
  always_comb begin
    half  = {{SP_W{1'b0}}, 1'b1} << (sh_r - SH_W'(1));
    sum   = {1'b0, prod_r} + half;
    x_nxt = X_W'(sum >> sh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_in;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sh_r   <= sh_nxt;
    x_r    <= x_nxt;
  end

  assign valid_out = v2_r;
  assign x_out     = x_r;

endmodule

// ===== hw/rtl/alux_horner.sv =====
module alux_horner #(
  parameter logic signed [alux_pkg::T_W-1:0] COEF  = alux_pkg::COEF2,
  parameter int unsigned                     SHIFT = 31
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_in,
  input  logic [alux_pkg::X_W-1:0]           x_in,
  input  logic signed [alux_pkg::T_W-1:0]    t_in,
  output logic                               valid_out,
  output logic [alux_pkg::X_W-1:0]           x_out,
  output logic signed [alux_pkg::T_W-1:0]    t_out
);
  import alux_pkg::*;

  localparam logic signed [P_W-1:0] HALF = {{(P_W-1){1'b0}}, 1'b1} << (SHIFT - 1);

  logic                    va_r, vb_r;
  logic [X_W-1:0]          xa_r, xb_r;
  logic signed [P_W-1:0]   p_r, p_nxt;
  logic signed [P_W-1:0]   sum, rnd;
  logic signed [T_W-1:0]   t_r, t_nxt;

  assign p_nxt = $signed({1'b0, x_in}) * t_in;

  // round half away from zero: negatives take one less before the arithmetic shift
  always_comb begin
    sum   = p_r + HALF - $signed({{(P_W-1){1'b0}}, p_r[P_W-1]});
    rnd   = sum >>> SHIFT;
    t_nxt = COEF + rnd[T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= valid_in;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r  <= p_nxt;
    xa_r <= x_in;
    t_r  <= t_nxt;
    xb_r <= xa_r;
  end

  assign valid_out = vb_r;
  assign x_out     = xb_r;
  assign t_out     = t_r;

endmodule

// ===== hw/rtl/alux_out.sv =====
module alux_out #(
  parameter int unsigned FRAC_BITS = alux_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_in,
  input  logic [alux_pkg::X_W-1:0]           x_in,
  input  logic signed [alux_pkg::T_W-1:0]    t_in,
  output logic                               valid_out,
  output logic [alux_pkg::LUX_W-1:0]         lux_out
);
  import alux_pkg::*;

  localparam int unsigned OSH = 36 - FRAC_BITS;
  localparam logic signed [P_W-1:0] HALF = {{(P_W-1){1'b0}}, 1'b1} << (OSH - 1);

  logic                    va_r, vb_r;
  logic signed [P_W-1:0]   p_r, p_nxt;
  logic signed [P_W-1:0]   sum, rnd;
  logic [LUX_W-1:0]        lux_r, lux_nxt;

  assign p_nxt = $signed({1'b0, x_in}) * t_in;

  always_comb begin
    sum = p_r + HALF - $signed({{(P_W-1){1'b0}}, p_r[P_W-1]});
    rnd = sum >>> OSH;
    priority if (rnd[P_W-1]) begin
      lux_nxt = '0;
    end else if (|rnd[P_W-2:LUX_W]) begin
      lux_nxt = LUX_MAX;
    end else begin
      lux_nxt = rnd[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= valid_in;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    lux_r <= lux_nxt;
  end

  assign valid_out = vb_r;
  assign lux_out   = lux_r;

endmodule

// ===== hw/rtl/ambient_light_counts_to_lux.sv =====
// A start transfer passes through u_scale, u_h2, u_h1, u_h0 and u_out to the out_valid strobe.
// Throughput: one count per cycle; busy is never raised. Depth is set by the 16x33
// scale multiply and four 32x34 multiply stages, each followed by a round stage.
// Results come out for exactly one cycle and cannot be held off.
// Synchronous active-low reset clears the pipeline valid bits and sets both
// configuration registers to code 0 (gain x1, 100 ms).
module ambient_light_counts_to_lux #(
  parameter int unsigned FRAC_BITS = alux_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [alux_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [alux_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [alux_pkg::RAW_W-1:0]     in_raw_count,
  output logic                           out_valid,
  output logic [alux_pkg::LUX_W-1:0]     out_lux_value
);
  import alux_pkg::*;

  logic [1:0]            gain_r, gain_nxt;
  logic [3:0]            itime_r, itime_nxt;
  logic                  v_x, v_t2, v_t1, v_t0;
  logic [X_W-1:0]        x_x, x_t2, x_t1, x_t0;
  logic signed [T_W-1:0] t2, t1, t0;

  always_comb begin
    gain_nxt  = gain_r;
    itime_nxt = itime_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN:  gain_nxt  = cfg_wdata[1:0];
        CFG_ITIME: itime_nxt = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_X1;
      itime_r <= IT_100MS;
    end else begin
      gain_r  <= gain_nxt;
      itime_r <= itime_nxt;
    end
  end

  assign busy = 1'b0;

  alux_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (start),
    .raw_in    (in_raw_count),
    .gain_in   (gain_r),
    .itime_in  (itime_r),
    .valid_out (v_x),
    .x_out     (x_x)
  );

  alux_horner #(.COEF(COEF2), .SHIFT(31)) u_h2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v_x),
    .x_in      (x_x),
    .t_in      (COEF3),
    .valid_out (v_t2),
    .x_out     (x_t2),
    .t_out     (t2)
  );

  alux_horner #(.COEF(COEF1), .SHIFT(31)) u_h1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v_t2),
    .x_in      (x_t2),
    .t_in      (t2),
    .valid_out (v_t1),
    .x_out     (x_t1),
    .t_out     (t1)
  );

  alux_horner #(.COEF(COEF0), .SHIFT(30)) u_h0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v_t1),
    .x_in      (x_t1),
    .t_in      (t1),
    .valid_out (v_t0),
    .x_out     (x_t0),
    .t_out     (t0)
  );

  alux_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v_t0),
    .x_in      (x_t0),
    .t_in      (t0),
    .valid_out (out_valid),
    .lux_out   (out_lux_value)
  );

endmodule

// ===== bench/ambient_light_counts_to_lux_checker.sv =====
`timescale 1ns / 1ps

module ambient_light_counts_to_lux_checker #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [alux_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [alux_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                           start,
  input  logic                           busy,
  input  logic [alux_pkg::RAW_W-1:0]     in_raw_count,
  input  logic                           out_valid,
  input  logic [alux_pkg::LUX_W-1:0]     out_lux_value,
  output int                             n_errors,
  output int                             n_pending,
  output int                             n_checked
);
  import alux_pkg::*;

  // 0.0072 in Q40 and the correction coefficients at their own scales
  localparam longint unsigned BASE_0072 = 64'd7916483720;
  localparam longint POLY_C3 = 64'sd2839795084;
  localparam longint POLY_C2 = -64'sd338396873;
  localparam longint POLY_C1 = 64'sd22399251;
  localparam longint POLY_C0 = 64'sd4203951;
  localparam longint LUX_TOP = (64'sd1 <<< 35) - 1;

  typedef struct {
    logic [RAW_W-1:0] raw;
    logic [1:0]       gain;
    logic [3:0]       itime;
    logic [LUX_W-1:0] lux;
  } lux_due_t;

  lux_due_t   lux_due[$];
  lux_due_t   head;
  logic [1:0] gain_q;
  logic [3:0] itime_q;

  // round half away from zero on the magnitude
  function automatic longint round_shift(input longint v, input int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic logic [LUX_W-1:0] lux_of(input logic [RAW_W-1:0] raw,
                                              input logic [1:0] gain,
                                              input logic [3:0] itime);
    int              e;
    int              sh;
    longint unsigned scaled;
    longint          x;
    longint          t2;
    longint          t1;
    longint          t0;
    longint          lux;
    case (itime)
      IT_100MS: e = 3;
      IT_200MS: e = 2;
      IT_400MS: e = 1;
      IT_800MS: e = 0;
      IT_50MS:  e = 4;
      default:  e = 5;  // 25 ms, also any unlisted code
    endcase
    case (gain)
      GAIN_X2:   e = e - 1;
      GAIN_DIV8: e = e + 3;
      GAIN_DIV4: e = e + 2;
      default:   e = e;
    endcase
    sh = 26 - e;
    scaled = (64'(raw) * BASE_0072 + (64'd1 << (sh - 1))) >> sh;
    x = longint'(scaled);
    t2 = POLY_C2 + round_shift(x * POLY_C3, 31);
    t1 = POLY_C1 + round_shift(x * t2, 31);
    t0 = POLY_C0 + round_shift(x * t1, 30);
    lux = round_shift(x * t0, 36 - int'(FRAC_BITS));
    if (lux < 0) return '0;
    if (lux > LUX_TOP) return LUX_TOP[LUX_W-1:0];
    return lux[LUX_W-1:0];
  endfunction

  task automatic report(input string msg);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_q = GAIN_X1;
      itime_q = IT_100MS;
      lux_due.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (out_valid !== 1'b1) begin
          report("out_valid is unknown");
        end else if (lux_due.size() == 0) begin
          report($sformatf("lux %0d with no transfer outstanding", out_lux_value));
        end else begin
          head = lux_due.pop_front();
          n_checked++;
          if (out_lux_value !== head.lux)
            report($sformatf("raw %0d gain %0d itime %0d: lux expected %0d got %0d",
                             head.raw, head.gain, head.itime, head.lux, out_lux_value));
        end
      end
      // a count transfers with the settings in force before this edge
      if (start && !busy)
        lux_due.push_back('{in_raw_count, gain_q, itime_q,
                            lux_of(in_raw_count, gain_q, itime_q)});
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:  gain_q = cfg_wdata[1:0];
          CFG_ITIME: itime_q = cfg_wdata[3:0];
          default:   ;
        endcase
      end
    end
    n_pending = lux_due.size();
  end

endmodule

// ===== bench/ambient_light_counts_to_lux_tb.sv =====
`timescale 1ns / 1ps

module ambient_light_counts_to_lux_tb;
  import alux_pkg::*;

  localparam int unsigned LUX_FRAC = 8;
  localparam logic [3:0] IT_25MS = 4'd12;
  localparam logic [3:0] IT_ODD_LO = 4'd4;
  localparam logic [3:0] IT_ODD_HI = 4'd15;
  localparam logic [CFG_IW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_SPARE_B = 2'd3;
  localparam int DIRECTED_SETS = 7;
  localparam int DIRECTED_COUNTS = 3 * (DIRECTED_SETS + 1);
  localparam int RANDOM_COUNTS = 1000;
  localparam int CALM_TAIL = 150;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [1:0] DIR_GAIN [DIRECTED_SETS] =
    '{GAIN_X2, GAIN_DIV8, GAIN_DIV4, GAIN_DIV8, GAIN_X1, GAIN_X2, GAIN_DIV4};
  localparam logic [3:0] DIR_ITIME [DIRECTED_SETS] =
    '{IT_800MS, IT_25MS, IT_50MS, IT_ODD_HI, IT_200MS, IT_400MS, IT_ODD_LO};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              start;
  logic              busy;
  logic [RAW_W-1:0]  in_raw_count;
  logic              out_valid;
  logic [LUX_W-1:0]  out_lux_value;
  int                n_errors;
  int                n_pending;
  int                n_checked;
  int                cycles = 0;
  int                counts_sent = 0;
  int                settings_used = 0;

  ambient_light_counts_to_lux #(.FRAC_BITS(LUX_FRAC)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_raw_count  (in_raw_count),
    .out_valid     (out_valid),
    .out_lux_value (out_lux_value)
  );

  ambient_light_counts_to_lux_checker #(.FRAC_BITS(LUX_FRAC)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_raw_count  (in_raw_count),
    .out_valid     (out_valid),
    .out_lux_value (out_lux_value),
    .n_errors      (n_errors),
    .n_pending     (n_pending),
    .n_checked     (n_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, n_pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [RAW_W-1:0] draw_count();
    logic [RAW_W-1:0] one_hot;
    one_hot = 16'd1 << $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      5:       return 16'($urandom_range(0, 255));
      6:       return 16'($urandom_range(65000, 65535));
      7:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      8:       return one_hot;
      9:       return ~one_hot;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_count(input logic [RAW_W-1:0] raw, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
        in_raw_count <= 16'($urandom);
      end
    end
    @(negedge clk);
    start <= 1'b1;
    in_raw_count <= raw;
    do @(posedge clk); while (busy);
    counts_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // hold off until every result is back, then change the settings
  task automatic drain_and_set(input logic [1:0] gain, input logic [3:0] itime);
    @(negedge clk);
    start <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    // upper data bits are junk that the gain register must drop
    write_reg(CFG_GAIN, {2'($urandom), gain});
    write_reg(CFG_ITIME, itime);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_B : CFG_SPARE_A, 4'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int         phase;
    int         len;
    int         total;
    logic [1:0] gain;
    logic [3:0] itime;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 1'b0;
    in_raw_count = '0;
    total = DIRECTED_COUNTS + RANDOM_COUNTS;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings first, then each gain and integration code, unlisted ones too
    settings_used++;
    send_count(16'h0000, 1'b1);
    send_count(16'hFFFF, 1'b1);
    send_count(draw_count(), 1'b1);
    for (phase = 0; phase < DIRECTED_SETS; phase++) begin
      drain_and_set(DIR_GAIN[phase], DIR_ITIME[phase]);
      send_count(16'hFFFF, 1'b1);
      send_count(16'h0000, 1'b1);
      send_count(draw_count(), 1'b1);
    end

    phase = 0;
    while (counts_sent < total) begin
      if (phase == 0) begin
        gain = GAIN_DIV8;
        itime = IT_25MS;
      end else if (phase == 1) begin
        gain = GAIN_X2;
        itime = IT_800MS;
      end else begin
        gain = 2'($urandom);
        itime = 4'($urandom);
      end
      drain_and_set(gain, itime);
      len = $urandom_range(80, 160);
      // once in the tail, keep streaming without another settings change
      while ((len > 0 || counts_sent >= total - CALM_TAIL) && counts_sent < total) begin
        send_count(draw_count(), counts_sent < total - CALM_TAIL);
        len--;
      end
      phase++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d counts under %0d gain/integration settings, %0d lux results checked.",
             counts_sent, settings_used, n_checked);
    $display("Settings spanned every gain code, listed and unlisted integration codes.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
